// File: hdl/tlbarr_pkg.sv
// ----------------------------------------------------------------------------
// tlbarr_pkg
// shared constants, request codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package tlbarr_pkg;

   localparam int NUM_ENTRIES_DEF = 64;
   localparam int PAGE_BITS_DEF   = 20;
   localparam int ID_BITS_DEF     = 8;
   localparam int FRAME_BITS_DEF  = 20;

   localparam int FLAG_BITS       = 10;
   localparam int CNT_BITS        = 32;
   localparam int TYPE_BITS       = 3;
   localparam int MODE_BITS       = 2;

   // first-match search is split into groups of this size
   localparam int GROUP_SIZE      = 16;
   localparam int GROUP_IDX_BITS  = 4;

   localparam logic [TYPE_BITS-1:0] REQ_LOOKUP     = 3'd0;
   localparam logic [TYPE_BITS-1:0] REQ_INSERT     = 3'd1;
   localparam logic [TYPE_BITS-1:0] REQ_FLUSH_ALL  = 3'd2;
   localparam logic [TYPE_BITS-1:0] REQ_FLUSH_PAGE = 3'd3;
   localparam logic [TYPE_BITS-1:0] REQ_FLUSH_ID   = 3'd4;
   localparam logic [TYPE_BITS-1:0] REQ_UPDATE     = 3'd5;

   localparam logic [MODE_BITS-1:0] MODE_PT_ONLY   = 2'd2;

   typedef struct packed {
      logic capture;
      logic compare;
      logic group;
      logic select;
      logic apply;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// File: hdl/tlbarr_ram.sv
// ----------------------------------------------------------------------------
// tlbarr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tlbarr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tlbarr_ctrl.sv
// ----------------------------------------------------------------------------
// tlbarr_ctrl
// request sequencer: capture, compare, group search, select, apply, output
// ----------------------------------------------------------------------------
module tlbarr_ctrl
   import tlbarr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MATCH  = 3'd1;
   localparam logic [2:0] ST_GROUP  = 3'd2;
   localparam logic [2:0] ST_SELECT = 3'd3;
   localparam logic [2:0] ST_APPLY  = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.compare = 1'b1;
            state_in    = ST_GROUP;
         end
         ST_GROUP: begin
            cmd.group = 1'b1;
            state_in  = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // wait here only while the previous result is still unclaimed
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.compare, cmd.group, cmd.select, cmd.apply, cmd.load_out}))
      else $error("more than one datapath command at once");

   a_apply_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> (state_ff == ST_OUT) && !req_tready)
      else $error("apply not followed by output stage");

   a_capture_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture == (req_tvalid && req_tready))
      else $error("capture does not match the request handshake");
`endif

endmodule

// File: hdl/tlbarr_dpath.sv
// ----------------------------------------------------------------------------
// tlbarr_dpath
// tag cells with parallel compare, two-level first-match search,
// frame/flag ram, counters and output register
// ----------------------------------------------------------------------------
module tlbarr_dpath
   import tlbarr_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   parameter int PAGE_BITS   = PAGE_BITS_DEF,
   parameter int ID_BITS     = ID_BITS_DEF,
   parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [TYPE_BITS-1:0]  req_type,
   input  logic [PAGE_BITS-1:0]  virt_page,
   input  logic [ID_BITS-1:0]    space_id,
   input  logic [FRAME_BITS-1:0] pte_frame,
   input  logic [FLAG_BITS-1:0]  pte_flags,
   input  logic                  pte_valid,
   input  logic                  pte_global,
   input  logic                  csr_wr_en,
   input  logic [MODE_BITS-1:0]  csr_wr_data,
   input  logic                  rsp_tready,
   output logic                  out_valid,
   output logic                  out_hit,
   output logic [PAGE_BITS-1:0]  out_entry_page,
   output logic [ID_BITS-1:0]    out_entry_id,
   output logic [FRAME_BITS-1:0] out_entry_frame,
   output logic [FLAG_BITS-1:0]  out_entry_flags,
   output logic                  out_entry_global,
   output logic [CNT_BITS-1:0]   out_hit_count,
   output logic [CNT_BITS-1:0]   out_miss_count,
   output logic [CNT_BITS-1:0]   out_insert_count
);

   localparam int IDX_BITS    = $clog2(NUM_ENTRIES);
   localparam int NUM_GROUPS  = (NUM_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GSEL_BITS   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int PAD_ENTRIES = NUM_GROUPS * GROUP_SIZE;
   localparam int FULL_BITS   = GSEL_BITS + GROUP_IDX_BITS;
   // ram word from low bits: frame, flags, page, id, global
   localparam int FLG_LO      = FRAME_BITS;
   localparam int PG_LO       = FLG_LO + FLAG_BITS;
   localparam int ID_LO       = PG_LO + PAGE_BITS;
   localparam int GL_POS      = ID_LO + ID_BITS;
   localparam int RAM_BITS    = GL_POS + 1;

   // request register
   logic [TYPE_BITS-1:0]  type_ff,  type_in;
   logic [PAGE_BITS-1:0]  page_ff,  page_in;
   logic [ID_BITS-1:0]    id_ff,    id_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [FLAG_BITS-1:0]  flags_ff, flags_in;
   logic                  nv_ff,    nv_in;
   logic                  ng_ff,    ng_in;

   // tag cells
   logic [PAGE_BITS-1:0]   tag_page_ff [NUM_ENTRIES];
   logic [PAGE_BITS-1:0]   tag_page_in [NUM_ENTRIES];
   logic [ID_BITS-1:0]     tag_id_ff   [NUM_ENTRIES];
   logic [ID_BITS-1:0]     tag_id_in   [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff,  valid_in;
   logic [NUM_ENTRIES-1:0] global_ff, global_in;

   // compare results
   logic [NUM_ENTRIES-1:0] page_eq_ff, page_eq_in;
   logic [NUM_ENTRIES-1:0] id_eq_ff,   id_eq_in;

   // search
   logic [PAD_ENTRIES-1:0]    cand_vec;
   logic [NUM_GROUPS-1:0]     grp_any_ff, grp_any_in;
   logic [GROUP_IDX_BITS-1:0] grp_idx_ff [NUM_GROUPS];
   logic [GROUP_IDX_BITS-1:0] grp_idx_in [NUM_GROUPS];
   logic [FULL_BITS-1:0]      full_idx;
   logic                      found_ff, found_in;
   logic [IDX_BITS-1:0]       idx_ff,   idx_in;

   logic [IDX_BITS-1:0]  ptr_ff,     ptr_in;
   logic [CNT_BITS-1:0]  hits_ff,    hits_in;
   logic [CNT_BITS-1:0]  misses_ff,  misses_in;
   logic [CNT_BITS-1:0]  inserts_ff, inserts_in;
   logic [MODE_BITS-1:0] mode_ff,    mode_in;
   logic                 hit_ff,     hit_in;

   logic                 out_valid_ff,   out_valid_in;
   logic                 out_hit_ff,     out_hit_in;
   logic [RAM_BITS-1:0]  out_word_ff,    out_word_in;
   logic [CNT_BITS-1:0]  out_hits_ff,    out_hits_in;
   logic [CNT_BITS-1:0]  out_misses_ff,  out_misses_in;
   logic [CNT_BITS-1:0]  out_inserts_ff, out_inserts_in;

   logic                 enabled;
   logic                 is_insert;
   logic                 is_update;
   logic                 is_lookup;
   logic                 ram_wr_en;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   logic [RAM_BITS-1:0]  ram_wr_data;
   logic                 ram_rd_en;
   logic [RAM_BITS-1:0]  ram_rd_data;

   assign enabled   = (mode_ff != MODE_PT_ONLY);
   assign is_insert = (type_ff == REQ_INSERT);
   assign is_update = (type_ff == REQ_UPDATE);
   assign is_lookup = (type_ff == REQ_LOOKUP);

   // request capture and mode register
   always_comb begin
      type_in  = type_ff;
      page_in  = page_ff;
      id_in    = id_ff;
      frame_in = frame_ff;
      flags_in = flags_ff;
      nv_in    = nv_ff;
      ng_in    = ng_ff;
      if (cmd.capture) begin
         type_in  = req_type;
         page_in  = virt_page;
         id_in    = space_id;
         frame_in = pte_frame;
         flags_in = pte_flags;
         nv_in    = pte_valid;
         ng_in    = pte_global;
      end
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   end

   // parallel tag compare
   always_comb begin
      page_eq_in = page_eq_ff;
      id_eq_in   = id_eq_ff;
      if (cmd.compare) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            page_eq_in[i] = (tag_page_ff[i] == page_ff);
            id_eq_in[i]   = (tag_id_ff[i] == id_ff);
         end
      end
   end

   // first stage of the search: first hit inside each group of entries
   always_comb begin
      cand_vec = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (is_lookup) begin
            cand_vec[i] = valid_ff[i] & page_eq_ff[i] & (id_eq_ff[i] | global_ff[i]);
         end else begin
            cand_vec[i] = page_eq_ff[i] & id_eq_ff[i];
         end
      end
      grp_any_in = grp_any_ff;
      grp_idx_in = grp_idx_ff;
      if (cmd.group) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_any_in[g] = 1'b0;
            grp_idx_in[g] = '0;
            for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
               if (cand_vec[g * GROUP_SIZE + k]) begin
                  grp_any_in[g] = 1'b1;
                  grp_idx_in[g] = GROUP_IDX_BITS'(k);
               end
            end
         end
      end
   end

   // second stage: first group that holds a hit
   always_comb begin
      full_idx = '0;
      found_in = found_ff;
      idx_in   = idx_ff;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            full_idx = {GSEL_BITS'(g), grp_idx_ff[g]};
         end
      end
      if (cmd.select) begin
         found_in = |grp_any_ff;
         idx_in   = full_idx[IDX_BITS-1:0];
      end
   end

   // tag cell updates
   always_comb begin
      tag_page_in = tag_page_ff;
      tag_id_in   = tag_id_ff;
      valid_in    = valid_ff;
      global_in   = global_ff;
      if (cmd.apply && enabled) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            unique case (type_ff)
               REQ_INSERT: begin
                  if (IDX_BITS'(i) == ptr_ff) begin
                     tag_page_in[i] = page_ff;
                     tag_id_in[i]   = id_ff;
                     valid_in[i]    = nv_ff;
                     global_in[i]   = ng_ff;
                  end
               end
               REQ_FLUSH_ALL: begin
                  if (!global_ff[i]) begin
                     valid_in[i] = 1'b0;
                  end
               end
               REQ_FLUSH_PAGE: begin
                  if (page_eq_ff[i]) begin
                     valid_in[i] = 1'b0;
                  end
               end
               REQ_FLUSH_ID: begin
                  if (id_eq_ff[i]) begin
                     valid_in[i] = 1'b0;
                  end
               end
               REQ_UPDATE: begin
                  if (found_ff && (IDX_BITS'(i) == idx_ff)) begin
                     valid_in[i]  = nv_ff;
                     global_in[i] = ng_ff;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // pointer, counters and lookup outcome
   always_comb begin
      ptr_in     = ptr_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      inserts_in = inserts_ff;
      hit_in     = hit_ff;
      if (cmd.apply) begin
         hit_in = enabled && is_lookup && found_ff;
         if (enabled && is_lookup) begin
            if (found_ff) begin
               hits_in = hits_ff + 1'b1;
            end else begin
               misses_in = misses_ff + 1'b1;
            end
         end
         if (enabled && is_insert) begin
            inserts_in = inserts_ff + 1'b1;
            ptr_in     = (ptr_ff == IDX_BITS'(NUM_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
         end
      end
   end

   // ram holds frame, flags and a copy of page, id and global per entry
   assign ram_wr_en   = cmd.apply && enabled && (is_insert || (is_update && found_ff));
   assign ram_wr_addr = is_insert ? ptr_ff : idx_ff;
   assign ram_wr_data = {ng_ff, id_ff, page_ff, flags_ff, frame_ff};
   assign ram_rd_en   = cmd.apply && is_lookup;

   tlbarr_ram #(
      .WIDTH (RAM_BITS),
      .DEPTH (NUM_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // output register, counters are frozen with the item they belong to
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_hit_in     = out_hit_ff;
      out_word_in    = out_word_ff;
      out_hits_in    = out_hits_ff;
      out_misses_in  = out_misses_ff;
      out_inserts_in = out_inserts_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         out_valid_in   = 1'b1;
         out_hit_in     = hit_ff;
         out_word_in    = hit_ff ? ram_rd_data : '0;
         out_hits_in    = hits_ff;
         out_misses_in  = misses_ff;
         out_inserts_in = inserts_ff;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_page_ff  <= '{default: '0};
         tag_id_ff    <= '{default: '0};
         valid_ff     <= '0;
         global_ff    <= '0;
         ptr_ff       <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         inserts_ff   <= '0;
         mode_ff      <= '0;
         found_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tag_page_ff  <= tag_page_in;
         tag_id_ff    <= tag_id_in;
         valid_ff     <= valid_in;
         global_ff    <= global_in;
         ptr_ff       <= ptr_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         inserts_ff   <= inserts_in;
         mode_ff      <= mode_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      page_ff        <= page_in;
      id_ff          <= id_in;
      frame_ff       <= frame_in;
      flags_ff       <= flags_in;
      nv_ff          <= nv_in;
      ng_ff          <= ng_in;
      page_eq_ff     <= page_eq_in;
      id_eq_ff       <= id_eq_in;
      grp_any_ff     <= grp_any_in;
      grp_idx_ff     <= grp_idx_in;
      idx_ff         <= idx_in;
      out_hit_ff     <= out_hit_in;
      out_word_ff    <= out_word_in;
      out_hits_ff    <= out_hits_in;
      out_misses_ff  <= out_misses_in;
      out_inserts_ff <= out_inserts_in;
   end

   assign out_valid        = out_valid_ff;
   assign out_hit          = out_hit_ff;
   assign out_entry_frame  = out_word_ff[FLG_LO-1:0];
   assign out_entry_flags  = out_word_ff[PG_LO-1:FLG_LO];
   assign out_entry_page   = out_word_ff[ID_LO-1:PG_LO];
   assign out_entry_id     = out_word_ff[GL_POS-1:ID_LO];
   assign out_entry_global = out_word_ff[GL_POS];
   assign out_hit_count    = out_hits_ff;
   assign out_miss_count   = out_misses_ff;
   assign out_insert_count = out_inserts_ff;

`ifndef SYNTHESIS
   a_lookup_hit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && is_lookup && found_ff |-> valid_ff[idx_ff])
      else $error("lookup selected an invalid entry");

   a_ptr_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && enabled && is_insert |=>
         ptr_ff == (($past(ptr_ff) == IDX_BITS'(NUM_ENTRIES - 1)) ? '0 : $past(ptr_ff) + 1'b1))
      else $error("replacement pointer did not advance");

   a_counters_quiet: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(cmd.apply) |->
         $stable(hits_ff) && $stable(misses_ff) && $stable(inserts_ff))
      else $error("counter changed outside the apply step");
`endif

endmodule

// File: hdl/tlb_asid_round_robin_top.sv
// ----------------------------------------------------------------------------
// tlb_asid_round_robin_top
// fully associative tlb with address-space ids and round-robin replacement
//
//   channel  ports          tuser            tdata (low bits first)
//   request  req_t*         req_type         virt_page, space_id, pte_frame,
//                                            pte_flags, pte_valid, pte_global
//   result   rsp_t*         hit              entry_page, entry_id, entry_frame,
//                                            entry_flags, entry_global,
//                                            hit_count, miss_count, insert_count
//   mode     csr_wr_en/data -                mmu_mode
//
// an item goes through accept, tag compare, group search, final select,
// apply (cell/ram write or ram read) and output load; these steps are set by
// the two-level first-match search and the registered ram read
// reset is synchronous and clears all tags, valid bits and counters at once
// a result waiting in the output register does not block the next item;
// that item stalls in its last step only while the register is still full
// ----------------------------------------------------------------------------
module tlb_asid_round_robin_top
   import tlbarr_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   parameter int PAGE_BITS   = PAGE_BITS_DEF,
   parameter int ID_BITS     = ID_BITS_DEF,
   parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // req_type
   input  logic [TYPE_BITS-1:0] req_tuser,
   // virt_page, space_id, pte_frame, pte_flags, pte_valid, pte_global
   input  logic [((PAGE_BITS + ID_BITS + FRAME_BITS + FLAG_BITS + 2 + 7) / 8) * 8 - 1:0]
                                req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // hit
   output logic [0:0]           rsp_tuser,
   // entry_page, entry_id, entry_frame, entry_flags, entry_global,
   // hit_count, miss_count, insert_count
   output logic [((PAGE_BITS + ID_BITS + FRAME_BITS + FLAG_BITS + 1 + 3 * CNT_BITS + 7)
                  / 8) * 8 - 1:0]
                                rsp_tdata,
   input  logic                 csr_wr_en,
   input  logic [MODE_BITS-1:0] csr_wr_data
);

   localparam int RSP_DATA_BITS = $bits(rsp_tdata);
   localparam int ID_LO         = PAGE_BITS;
   localparam int FRM_LO        = ID_LO + ID_BITS;
   localparam int FLG_LO        = FRM_LO + FRAME_BITS;
   localparam int VAL_POS       = FLG_LO + FLAG_BITS;
   localparam int GLB_POS       = VAL_POS + 1;

   cmd_type    cmd;
   status_type status;

   logic                  out_hit;
   logic [PAGE_BITS-1:0]  out_entry_page;
   logic [ID_BITS-1:0]    out_entry_id;
   logic [FRAME_BITS-1:0] out_entry_frame;
   logic [FLAG_BITS-1:0]  out_entry_flags;
   logic                  out_entry_global;
   logic [CNT_BITS-1:0]   out_hit_count;
   logic [CNT_BITS-1:0]   out_miss_count;
   logic [CNT_BITS-1:0]   out_insert_count;

   tlbarr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tlbarr_dpath #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .ID_BITS     (ID_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_tuser),
      .virt_page        (req_tdata[ID_LO-1:0]),
      .space_id         (req_tdata[FRM_LO-1:ID_LO]),
      .pte_frame        (req_tdata[FLG_LO-1:FRM_LO]),
      .pte_flags        (req_tdata[VAL_POS-1:FLG_LO]),
      .pte_valid        (req_tdata[VAL_POS]),
      .pte_global       (req_tdata[GLB_POS]),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_tready       (rsp_tready),
      .out_valid        (rsp_tvalid),
      .out_hit          (out_hit),
      .out_entry_page   (out_entry_page),
      .out_entry_id     (out_entry_id),
      .out_entry_frame  (out_entry_frame),
      .out_entry_flags  (out_entry_flags),
      .out_entry_global (out_entry_global),
      .out_hit_count    (out_hit_count),
      .out_miss_count   (out_miss_count),
      .out_insert_count (out_insert_count)
   );

   assign rsp_tuser = out_hit;
   // upper pad bits are zero
   assign rsp_tdata = RSP_DATA_BITS'({out_insert_count, out_miss_count, out_hit_count,
                                      out_entry_global, out_entry_flags, out_entry_frame,
                                      out_entry_id, out_entry_page});

endmodule
